// ===== hdl/histeq_pkg.sv =====
// Shared constants and types for the histogram equalizer.
package histeq_pkg;

   localparam int CSR_W           = 13;
   localparam int PIX_W           = 8;
   localparam int LEVELS          = 256;
   localparam int LEVEL_W         = 8;
   localparam int MAX_DIM_DEFAULT = 4096;
   localparam int CSR_IDX_W       = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_MAP        = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/heq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module heq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/heq_divider.sv =====
// Iterative divider that forms floor(255*cum/total), saturated to 255, one bit a cycle.
module heq_divider #(
   parameter int CNT_W = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [CNT_W-1:0]                   cum,
   input  logic [CNT_W-1:0]                   total,
   output histeq_pkg::div_status_type         status,
   output logic [histeq_pkg::LEVEL_W-1:0]     quotient
);

   localparam int LW = histeq_pkg::LEVEL_W;
   localparam int STEP_W = $clog2(LW + 1);

   logic [CNT_W:0]        rem_ff, rem_in;
   logic [LW-1:0]         low_ff, low_in;
   logic [LW-1:0]         q_ff, q_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W+LW-1:0]   prod;
   logic [CNT_W:0]        trial;

   always_comb begin
      prod    = {cum, {LW{1'b0}}} - {{LW{1'b0}}, cum};
      trial   = {rem_ff[CNT_W-1:0], low_ff[LW-1]};
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         if (cum >= total) begin
            q_in    = {LW{1'b1}};
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = {1'b0, prod[CNT_W+LW-1:LW]};
            low_in  = prod[LW-1:0];
            q_in    = '0;
            step_in = STEP_W'(LW);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, total}) begin
            rem_in = trial - {1'b0, total};
            q_in   = {q_ff[LW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[LW-2:0], 1'b0};
         end
         low_in  = {low_ff[LW-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// ===== hdl/histogram_equalizer.sv =====
// Top level of the two-pass 8-bit histogram equalizer.
// An accumulate beat reads the bin, then writes back the incremented count; an ignored
// accumulate beat returns straight to idle. A map beat reads the level map and then
// offers its result, waiting while the result port stalls; the first map beat of a frame
// first builds the 256-entry table level by level on the shared one-bit-per-cycle divider.
// The histogram clears at the end of a frame through per-bin valid flags.
module histogram_equalizer #(
   parameter int MAX_DIM = histeq_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [histeq_pkg::PIX_W-1:0]         req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [histeq_pkg::LEVEL_W-1:0]       rsp_mapped_pixel,
   output logic                                 rsp_frame_done,
   input  logic                                 csr_write,
   input  logic [histeq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [histeq_pkg::CSR_W-1:0]         csr_data
);

   localparam int CW     = histeq_pkg::CSR_W;
   localparam int PW     = histeq_pkg::PIX_W;
   localparam int LW     = histeq_pkg::LEVEL_W;
   localparam int NL     = histeq_pkg::LEVELS;
   localparam int AW     = $clog2(NL);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ACC_RD = 4'd1;
   localparam logic [3:0] S_ACC_WR = 4'd2;
   localparam logic [3:0] S_B_RD   = 4'd3;
   localparam logic [3:0] S_B_ADD  = 4'd4;
   localparam logic [3:0] S_B_DIV  = 4'd5;
   localparam logic [3:0] S_B_WAIT = 4'd6;
   localparam logic [3:0] S_M_RD   = 4'd7;
   localparam logic [3:0] S_M_OUT  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CW-1:0]    width_ff, height_ff;
   logic [PW-1:0]    pix_ff, pix_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cum_ff, cum_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic             map_ready_ff, map_ready_in;
   logic [NL-1:0]    bin_valid_ff, bin_valid_in;
   logic             done_ff, done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]    rsp_map_ff, rsp_map_in;
   logic             rsp_done_ff, rsp_done_in;

   logic [DIM_W-1:0]   dim_w, dim_h;
   logic [2*DIM_W-1:0] total_full;
   logic [CNT_W-1:0]   total;
   logic [CNT_W-1:0]   cnt_next;
   logic               accept;

   logic [AW-1:0]    bin_rd_addr;
   logic [CNT_W-1:0] bin_rd_data;
   logic             bin_wr_en;
   logic [CNT_W-1:0] bin_wr_data;
   logic [CNT_W-1:0] bin_value;
   logic             map_wr_en;
   logic [LW-1:0]    map_rd_data;
   logic             div_start;
   logic [LW-1:0]    div_q;
   histeq_pkg::div_status_type div_status;

   always_comb begin
      if (width_ff == '0) begin
         dim_w = DIM_W'(1);
      end else if ({1'b0, width_ff} > (CW+1)'(MAX_DIM)) begin
         dim_w = DIM_W'(MAX_DIM);
      end else begin
         dim_w = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         dim_h = DIM_W'(1);
      end else if ({1'b0, height_ff} > (CW+1)'(MAX_DIM)) begin
         dim_h = DIM_W'(MAX_DIM);
      end else begin
         dim_h = DIM_W'(height_ff);
      end
      total_full = dim_w * dim_h;
      total      = CNT_W'(total_full);
   end

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != S_IDLE);
   assign cnt_next    = cnt_ff + 1'b1;
   assign bin_value   = bin_valid_ff[pix_ff] ? bin_rd_data : '0;
   assign bin_rd_addr = (state_ff == S_B_RD) ? idx_ff : AW'(pix_ff);
   assign bin_wr_en   = (state_ff == S_ACC_WR);
   assign bin_wr_data = bin_value + 1'b1;
   assign div_start   = (state_ff == S_B_DIV);
   assign map_wr_en   = (state_ff == S_B_WAIT) && div_status.done;

   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      cnt_in       = cnt_ff;
      cum_in       = cum_ff;
      idx_in       = idx_ff;
      map_ready_in = map_ready_ff;
      bin_valid_in = bin_valid_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_map_in   = rsp_map_ff;
      rsp_done_in  = rsp_done_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pix_in = req_pixel;
               if (req_command == histeq_pkg::CMD_ACCUMULATE) begin
                  if (!map_ready_ff && cnt_ff < total) begin
                     cnt_in   = cnt_next;
                     state_in = S_ACC_RD;
                  end
               end else if (!map_ready_ff) begin
                  map_ready_in = 1'b1;
                  cnt_in       = '0;
                  cum_in       = '0;
                  idx_in       = '0;
                  state_in     = S_B_RD;
               end else begin
                  state_in = S_M_RD;
               end
            end
         end
         S_ACC_RD: begin
            state_in = S_ACC_WR;
         end
         S_ACC_WR: begin
            bin_valid_in[pix_ff] = 1'b1;
            state_in             = S_IDLE;
         end
         S_B_RD: begin
            state_in = S_B_ADD;
         end
         S_B_ADD: begin
            cum_in   = cum_ff + (bin_valid_ff[idx_ff] ? bin_rd_data : '0);
            state_in = S_B_DIV;
         end
         S_B_DIV: begin
            state_in = S_B_WAIT;
         end
         S_B_WAIT: begin
            if (div_status.done) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == AW'(NL - 1)) begin
                  state_in = S_M_RD;
               end else begin
                  state_in = S_B_RD;
               end
            end
         end
         S_M_RD: begin
            done_in = (cnt_next >= total);
            if (cnt_next >= total) begin
               bin_valid_in = '0;
               cnt_in       = '0;
               map_ready_in = 1'b0;
            end else begin
               cnt_in = cnt_next;
            end
            state_in = S_M_OUT;
         end
         S_M_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_map_in   = map_rd_data;
               rsp_done_in  = done_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= CW'(640);
         height_ff    <= CW'(480);
         cnt_ff       <= '0;
         map_ready_ff <= 1'b0;
         bin_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         map_ready_ff <= map_ready_in;
         bin_valid_ff <= bin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               histeq_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
               histeq_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
      end
      pix_ff      <= pix_in;
      cum_ff      <= cum_in;
      idx_ff      <= idx_in;
      done_ff     <= done_in;
      rsp_map_ff  <= rsp_map_in;
      rsp_done_ff <= rsp_done_in;
   end

   heq_ram #(.WIDTH(CNT_W), .DEPTH(NL)) u_bins (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (AW'(pix_ff)),
      .wr_data (bin_wr_data),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rd_data)
   );

   heq_ram #(.WIDTH(LW), .DEPTH(NL)) u_level_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (idx_ff),
      .wr_data (div_q),
      .rd_addr (AW'(pix_ff)),
      .rd_data (map_rd_data)
   );

   heq_divider #(.CNT_W(CNT_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .cum      (cum_ff),
      .total    (total),
      .status   (div_status),
      .quotient (div_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = rsp_map_ff;
   assign rsp_frame_done   = rsp_done_ff;

endmodule

// ===== hdl/heq_checker.sv =====
// Port-level assertions for the histogram equalizer, bound to its top level.
module heq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_command,
   input logic                              rsp_valid,
   input logic                              rsp_stall
);

   // A result beat that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result beat dropped while stalled.");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   // An accepted accumulate beat never produces a result beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == histeq_pkg::CMD_ACCUMULATE && !rsp_valid
      |=> !rsp_valid)
      else $error("Accumulate beat produced a result.");

   // A map beat keeps the input side busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == histeq_pkg::CMD_MAP |=> req_stall)
      else $error("Input accepted during a map beat.");

endmodule

bind histogram_equalizer heq_checker u_heq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall)
);
